// File: rtl/wide_line_quad_expander_unit_defines.svh
// assertion macros for the rtl
`ifndef WIDE_LINE_QUAD_EXPANDER_UNIT_DEFINES_SVH
`define WIDE_LINE_QUAD_EXPANDER_UNIT_DEFINES_SVH

// condition holds in the cycle after the trigger
`define WLQE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition holds in the same cycle as the trigger
`define WLQE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/wlqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wlqe_pkg;

   localparam int COORD_BITS_DEFAULT = 32;
   localparam int WIDTH_BITS         = 31;
   localparam int COLOR_BITS         = 32;
   localparam int ZTHR_BITS          = 63;
   localparam int DTHR_BITS          = 32;
   localparam int CSR_DATA_BITS      = 64;
   localparam int CSR_ADDR_BITS      = 4;
   localparam int REG_INDEX_LSB      = 3;

   localparam logic [ZTHR_BITS-1:0] ZTHR_RESET = 63'd4295;
   localparam logic [DTHR_BITS-1:0] DTHR_RESET = 32'd43;

   typedef logic [1:0] corner_type;
   localparam corner_type CORNER_A = 2'd0;
   localparam corner_type CORNER_B = 2'd1;
   localparam corner_type CORNER_C = 2'd2;
   localparam corner_type CORNER_D = 2'd3;

   typedef logic reg_index_type;
   localparam reg_index_type REG_ZTHR = 1'b0;
   localparam reg_index_type REG_DTHR = 1'b1;

endpackage

`default_nettype wire

// File: rtl/wide_line_quad_expander_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wide_line_quad_expander_unit_defines.svh"

// channel  | direction | word
// req      | in        | one segment: two endpoints, width, color
// rsp      | out       | one quad corner, tlast on the fourth
// csr      | in/out    | threshold registers, 64-bit data
//
// a new segment is taken only while no quad is held or its fourth rsp word is taken
// a req word passes six front stages, the divide entry stage, a 62-stage divide,
// a 31-stage square root and the output register before its first rsp word is valid
// reset clears valid bits and corner count and loads the threshold defaults
// a stall on rsp freezes the whole pipeline, req_tready drops with it

module wide_line_quad_expander_unit
   import wlqe_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   localparam int REQ_BITS = ((6 * COORD_BITS + WIDTH_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((3 * COORD_BITS + COLOR_BITS + 2 + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, line_width, line_color
   input  logic [REQ_BITS-1:0]      req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // vertex_x, vertex_y, vertex_z, vertex_color, corner_index
   output logic [RSP_BITS-1:0]      rsp_tdata,
   output logic                     rsp_tlast,
   // is_square
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CB   = COORD_BITS;
   localparam int HB   = (CB + 1) / 2;
   localparam int HH   = CB - HB;
   localparam int SQ   = 2 * CB;
   localparam int XW   = 2 * CB + 1;
   localparam int LW   = 2 * CB + 2;
   localparam int NCH  = (LW + 31) / 32;
   localparam int RHW  = 32 + NCH * 32;
   localparam int ZCW  = (LW > ZTHR_BITS) ? LW : ZTHR_BITS;
   localparam int WB   = WIDTH_BITS;
   localparam int W2B  = 2 * WIDTH_BITS;
   localparam int RW   = XW + 2;
   localparam int DV   = W2B;
   localparam int SN   = WB;
   localparam int RRW  = WB + 4;
   localparam int OB   = (CB > WB + 1) ? CB : WB + 1;

   typedef struct packed {
      logic [CB-1:0]         sx, sy, sz, ex, ey, ez;
      logic [COLOR_BITS-1:0] color;
      logic [WB-1:0]         half;
      logic                  negx, negy, square, degen;
   } pl_type;

   typedef struct packed {
      logic [CB-1:0]         sx, sy, sz, ex, ey, ez;
      logic [COLOR_BITS-1:0] color;
      logic [CB-1:0]         ox, oy;
      logic                  square;
   } hold_type;

   logic adv;

   // csr
   logic [ZTHR_BITS-1:0] zthr_ff, zthr_in;
   logic [DTHR_BITS-1:0] dthr_ff, dthr_in;
   logic                 csr_wr;
   reg_index_type        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[REG_INDEX_LSB];

   always_comb begin
      zthr_in = zthr_ff;
      dthr_in = dthr_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         REG_ZTHR: begin
            csr_prdata = CSR_DATA_BITS'(zthr_ff);
            if (csr_wr) zthr_in = csr_pwdata[ZTHR_BITS-1:0];
         end
         REG_DTHR: begin
            csr_prdata = CSR_DATA_BITS'(dthr_ff);
            if (csr_wr) dthr_in = csr_pwdata[DTHR_BITS-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zthr_ff <= ZTHR_RESET;
         dthr_ff <= DTHR_RESET;
      end else begin
         zthr_ff <= zthr_in;
         dthr_ff <= dthr_in;
      end
   end

   // stage 1: differences and magnitudes
   logic [CB-1:0]   in_s [3];
   logic [CB-1:0]   in_e [3];
   logic [WB-1:0]   in_w;
   logic signed [CB:0] dif [3];
   logic [WB:0]     wp1;
   pl_type          st1_pl_ff, st1_pl_in;
   logic [CB-1:0]   st1_mag_ff [3], st1_mag_in [3];
   logic [WB-1:0]   st1_w_ff;
   logic            st1_v_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         in_s[a] = req_tdata[a*CB +: CB];
         in_e[a] = req_tdata[(a+3)*CB +: CB];
         dif[a]  = $signed({in_e[a][CB-1], in_e[a]}) - $signed({in_s[a][CB-1], in_s[a]});
         st1_mag_in[a] = dif[a][CB] ? CB'(-dif[a]) : dif[a][CB-1:0];
      end
      in_w = req_tdata[6*CB +: WB];
      wp1  = (WB+1)'(in_w) + (WB+1)'(1);
      st1_pl_in.sx     = in_s[0];
      st1_pl_in.sy     = in_s[1];
      st1_pl_in.sz     = in_s[2];
      st1_pl_in.ex     = in_e[0];
      st1_pl_in.ey     = in_e[1];
      st1_pl_in.ez     = in_e[2];
      st1_pl_in.color  = req_tdata[6*CB+WB +: COLOR_BITS];
      st1_pl_in.half   = wp1[WB:1];
      st1_pl_in.negx   = !dif[1][CB] && (dif[1] != '0);
      st1_pl_in.negy   = dif[0][CB];
      st1_pl_in.square = 1'b0;
      st1_pl_in.degen  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st1_pl_ff  <= st1_pl_in;
         st1_mag_ff <= st1_mag_in;
         st1_w_ff   <= in_w;
      end
   end

   // stage 2: partial products of the squares
   pl_type          st2_pl_ff;
   logic [2*HH-1:0] st2_hh_ff [3], st2_hh_in [3];
   logic [CB-1:0]   st2_hl_ff [3], st2_hl_in [3];
   logic [2*HB-1:0] st2_ll_ff [3], st2_ll_in [3];
   logic [W2B-1:0]  st2_w2_ff, st2_w2_in;
   logic            st2_v_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         st2_hh_in[a] = (2*HH)'(st1_mag_ff[a][CB-1:HB]) * (2*HH)'(st1_mag_ff[a][CB-1:HB]);
         st2_hl_in[a] = CB'(st1_mag_ff[a][CB-1:HB]) * CB'(st1_mag_ff[a][HB-1:0]);
         st2_ll_in[a] = (2*HB)'(st1_mag_ff[a][HB-1:0]) * (2*HB)'(st1_mag_ff[a][HB-1:0]);
      end
      st2_w2_in = W2B'(st1_w_ff) * W2B'(st1_w_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st2_pl_ff <= st1_pl_ff;
         st2_hh_ff <= st2_hh_in;
         st2_hl_ff <= st2_hl_in;
         st2_ll_ff <= st2_ll_in;
         st2_w2_ff <= st2_w2_in;
      end
   end

   // stage 3: squares
   pl_type          st3_pl_ff;
   logic [SQ-1:0]   st3_q_ff [3], st3_q_in [3];
   logic [W2B-1:0]  st3_w2_ff;
   logic            st3_v_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         st3_q_in[a] = (SQ'(st2_hh_ff[a]) << (2*HB)) + (SQ'(st2_hl_ff[a]) << (HB+1))
                     + SQ'(st2_ll_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st3_pl_ff <= st2_pl_ff;
         st3_q_ff  <= st3_q_in;
         st3_w2_ff <= st2_w2_ff;
      end
   end

   // stage 4: xy and full squared length
   pl_type          st4_pl_ff;
   logic [XW-1:0]   st4_xy2_ff, st4_xy2_in;
   logic [LW-1:0]   st4_len2_ff, st4_len2_in;
   logic [SQ-1:0]   st4_qx_ff, st4_qy_ff;
   logic [W2B-1:0]  st4_w2_ff;
   logic            st4_v_ff;

   assign st4_xy2_in  = XW'(st3_q_ff[0]) + XW'(st3_q_ff[1]);
   assign st4_len2_in = LW'(st4_xy2_in) + LW'(st3_q_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         st4_pl_ff   <= st3_pl_ff;
         st4_xy2_ff  <= st4_xy2_in;
         st4_len2_ff <= st4_len2_in;
         st4_qx_ff   <= st3_q_ff[0];
         st4_qy_ff   <= st3_q_ff[1];
         st4_w2_ff   <= st3_w2_ff;
      end
   end

   // stage 5: square test and threshold partial products
   pl_type          st5_pl_ff, st5_pl_in;
   logic [XW-1:0]   st5_xy2_ff;
   logic            st5_xy2z_ff;
   logic [63:0]     st5_pp_ff [NCH], st5_pp_in [NCH];
   logic [NCH*32-1:0] len2p;
   logic [SQ-1:0]   st5_qx_ff, st5_qy_ff;
   logic [W2B-1:0]  st5_w2_ff;
   logic            st5_v_ff;

   always_comb begin
      len2p = (NCH*32)'(st4_len2_ff);
      for (int k = 0; k < NCH; k++) begin
         st5_pp_in[k] = 64'(dthr_ff) * 64'(len2p[32*k +: 32]);
      end
      st5_pl_in = st4_pl_ff;
      st5_pl_in.square = ZCW'(st4_len2_ff) < ZCW'(zthr_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st5_pl_ff   <= st5_pl_in;
         st5_xy2_ff  <= st4_xy2_ff;
         st5_xy2z_ff <= st4_xy2_ff == '0;
         st5_pp_ff   <= st5_pp_in;
         st5_qx_ff   <= st4_qx_ff;
         st5_qy_ff   <= st4_qy_ff;
         st5_w2_ff   <= st4_w2_ff;
      end
   end

   // stage 6: threshold times length
   pl_type          st6_pl_ff;
   logic [XW-1:0]   st6_xy2_ff;
   logic            st6_xy2z_ff;
   logic [RHW-1:0]  st6_rhs_ff, st6_rhs_in;
   logic [SQ-1:0]   st6_qx_ff, st6_qy_ff;
   logic [W2B-1:0]  st6_w2_ff;
   logic            st6_v_ff;

   always_comb begin
      st6_rhs_in = '0;
      for (int k = 0; k < NCH; k++) begin
         st6_rhs_in = st6_rhs_in + (RHW'(st5_pp_ff[k]) << (32*k));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st6_pl_ff   <= st5_pl_ff;
         st6_xy2_ff  <= st5_xy2_ff;
         st6_xy2z_ff <= st5_xy2z_ff;
         st6_rhs_ff  <= st6_rhs_in;
         st6_qx_ff   <= st5_qx_ff;
         st6_qy_ff   <= st5_qy_ff;
         st6_w2_ff   <= st5_w2_ff;
      end
   end

   // divide pipe: quo = c^2 * w^2 / xy2, one bit of w^2 per stage
   pl_type          dv_pl_ff   [DV+1];
   logic [RW-1:0]   dv_rem_ff  [DV+1][2];
   logic [W2B-1:0]  dv_quo_ff  [DV+1][2];
   logic [SQ-1:0]   dv_csq_ff  [DV+1][2];
   logic [XW-1:0]   dv_d_ff    [DV+1];
   logic [W2B-1:0]  dv_w2_ff   [DV+1];
   logic            dv_v_ff    [DV+1];
   pl_type          dv0_pl_in;

   always_comb begin
      dv0_pl_in = st6_pl_ff;
      dv0_pl_in.degen = st6_xy2z_ff || ((RHW'(st6_xy2_ff) << 32) < st6_rhs_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_pl_ff[0]     <= dv0_pl_in;
         dv_rem_ff[0][0] <= '0;
         dv_rem_ff[0][1] <= '0;
         dv_quo_ff[0][0] <= '0;
         dv_quo_ff[0][1] <= '0;
         dv_csq_ff[0][0] <= st6_qy_ff;
         dv_csq_ff[0][1] <= st6_qx_ff;
         dv_d_ff[0]      <= st6_xy2_ff;
         dv_w2_ff[0]     <= st6_w2_ff;
      end
   end

   for (genvar i = 1; i <= DV; i++) begin : g_div
      for (genvar j = 0; j < 2; j++) begin : g_lane
         logic [RW-1:0] t_in, d1, d2, rem_in;
         logic [1:0]    dig_in;
         always_comb begin
            t_in = {dv_rem_ff[i-1][j][RW-2:0], 1'b0}
                 + (dv_w2_ff[i-1][W2B-i] ? RW'(dv_csq_ff[i-1][j]) : RW'(0));
            d1 = RW'(dv_d_ff[i-1]);
            d2 = d1 << 1;
            if (t_in >= d2) begin
               rem_in = t_in - d2;
               dig_in = 2'd2;
            end else if (t_in >= d1) begin
               rem_in = t_in - d1;
               dig_in = 2'd1;
            end else begin
               rem_in = t_in;
               dig_in = 2'd0;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[i][j] <= rem_in;
               dv_quo_ff[i][j] <= {dv_quo_ff[i-1][j][W2B-2:0], 1'b0} + W2B'(dig_in);
               dv_csq_ff[i][j] <= dv_csq_ff[i-1][j];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_pl_ff[i] <= dv_pl_ff[i-1];
            dv_d_ff[i]  <= dv_d_ff[i-1];
            dv_w2_ff[i] <= dv_w2_ff[i-1];
         end
      end
   end

   // square root pipe, two radicand bits per stage
   pl_type          sq_pl_ff   [SN];
   logic [W2B-1:0]  sq_rad_ff  [SN][2];
   logic [WB-1:0]   sq_root_ff [SN][2];
   logic [RRW-1:0]  sq_rem_ff  [SN][2];
   logic            sq_v_ff    [SN];

   for (genvar k = 0; k < SN; k++) begin : g_sqrt
      pl_type pl_src;
      if (k == 0) begin : g_first
         assign pl_src = dv_pl_ff[DV];
      end else begin : g_next
         assign pl_src = sq_pl_ff[k-1];
      end
      for (genvar j = 0; j < 2; j++) begin : g_lane
         logic [W2B-1:0] rad_src;
         logic [WB-1:0]  root_src, root_in;
         logic [RRW-1:0] rem_src, r2, trial, rem_in;
         if (k == 0) begin : g_first
            assign rad_src  = dv_quo_ff[DV][j];
            assign root_src = '0;
            assign rem_src  = '0;
         end else begin : g_next
            assign rad_src  = sq_rad_ff[k-1][j];
            assign root_src = sq_root_ff[k-1][j];
            assign rem_src  = sq_rem_ff[k-1][j];
         end
         always_comb begin
            r2    = {rem_src[RRW-3:0], rad_src[W2B-1 -: 2]};
            trial = RRW'({root_src, 2'b01});
            if (r2 >= trial) begin
               rem_in  = r2 - trial;
               root_in = {root_src[WB-2:0], 1'b1};
            end else begin
               rem_in  = r2;
               root_in = {root_src[WB-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_rad_ff[k][j]  <= rad_src << 2;
               sq_root_ff[k][j] <= root_in;
               sq_rem_ff[k][j]  <= rem_in;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) sq_pl_ff[k] <= pl_src;
      end
   end

   // offsets into the output word register
   pl_type          fin_pl;
   logic [WB:0]     mx1, my1;
   logic [OB-1:0]   mx_e, my_e, half_e, oxf, oyf;
   hold_type        hold_ff, hold_in;
   logic            hold_v_ff;
   corner_type      cnt_ff, cnt_in;

   always_comb begin
      fin_pl = sq_pl_ff[SN-1];
      mx1    = (WB+1)'(sq_root_ff[SN-1][0]) + (WB+1)'(1);
      my1    = (WB+1)'(sq_root_ff[SN-1][1]) + (WB+1)'(1);
      mx_e   = OB'(mx1[WB:1]);
      my_e   = OB'(my1[WB:1]);
      half_e = OB'(fin_pl.half);
      if (fin_pl.square) begin
         oxf = half_e;
         oyf = half_e;
      end else if (fin_pl.degen) begin
         oxf = half_e;
         oyf = '0;
      end else begin
         oxf = fin_pl.negx ? -mx_e : mx_e;
         oyf = fin_pl.negy ? -my_e : my_e;
      end
      hold_in.sx     = fin_pl.sx;
      hold_in.sy     = fin_pl.sy;
      hold_in.sz     = fin_pl.sz;
      hold_in.ex     = fin_pl.ex;
      hold_in.ey     = fin_pl.ey;
      hold_in.ez     = fin_pl.ez;
      hold_in.color  = fin_pl.color;
      hold_in.ox     = oxf[CB-1:0];
      hold_in.oy     = oyf[CB-1:0];
      hold_in.square = fin_pl.square;
   end

   always_ff @(posedge clock) begin
      if (adv) hold_ff <= hold_in;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_v_ff  <= 1'b0;
         st2_v_ff  <= 1'b0;
         st3_v_ff  <= 1'b0;
         st4_v_ff  <= 1'b0;
         st5_v_ff  <= 1'b0;
         st6_v_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
         for (int i = 0; i <= DV; i++) dv_v_ff[i] <= 1'b0;
         for (int k = 0; k < SN; k++) sq_v_ff[k] <= 1'b0;
      end else if (adv) begin
         st1_v_ff   <= req_tvalid;
         st2_v_ff   <= st1_v_ff;
         st3_v_ff   <= st2_v_ff;
         st4_v_ff   <= st3_v_ff;
         st5_v_ff   <= st4_v_ff;
         st6_v_ff   <= st5_v_ff;
         dv_v_ff[0] <= st6_v_ff;
         for (int i = 1; i <= DV; i++) dv_v_ff[i] <= dv_v_ff[i-1];
         sq_v_ff[0] <= dv_v_ff[DV];
         for (int k = 1; k < SN; k++) sq_v_ff[k] <= sq_v_ff[k-1];
         hold_v_ff  <= sq_v_ff[SN-1];
      end
   end

   // corner sequencing
   logic rsp_take;
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign adv      = !hold_v_ff || (rsp_take && cnt_ff == CORNER_D);
   assign req_tready = adv;
   assign cnt_in   = rsp_take ? cnt_ff + 2'd1 : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= CORNER_A;
      else       cnt_ff <= cnt_in;
   end

   logic          use_end, addx, addy;
   logic [CB-1:0] bx, by, vx, vy, vz;

   always_comb begin
      use_end = !hold_ff.square && (cnt_ff == CORNER_C || cnt_ff == CORNER_D);
      if (hold_ff.square) begin
         addx = cnt_ff == CORNER_B || cnt_ff == CORNER_C;
         addy = cnt_ff == CORNER_C || cnt_ff == CORNER_D;
      end else begin
         addx = cnt_ff == CORNER_A || cnt_ff == CORNER_D;
         addy = addx;
      end
      bx = use_end ? hold_ff.ex : hold_ff.sx;
      by = use_end ? hold_ff.ey : hold_ff.sy;
      vz = use_end ? hold_ff.ez : hold_ff.sz;
      vx = addx ? bx + hold_ff.ox : bx - hold_ff.ox;
      vy = addy ? by + hold_ff.oy : by - hold_ff.oy;
   end

   assign rsp_tvalid = hold_v_ff;
   assign rsp_tdata  = RSP_BITS'({cnt_ff, hold_ff.color, vz, vy, vx});
   assign rsp_tlast  = cnt_ff == CORNER_D;
   assign rsp_tuser  = hold_ff.square;

   `WLQE_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, $stable(cnt_ff) && hold_v_ff, "corner or word lost under stall")
   `WLQE_ASSERT_NEXT(a_corner_wrap, clock, reset, rsp_take && cnt_ff == CORNER_D, cnt_ff == CORNER_A, "corner count did not wrap")
   `WLQE_ASSERT_NEXT(a_div_enter, clock, reset, adv, dv_v_ff[0] == $past(st6_v_ff), "divider entry valid mismatch")
   `WLQE_ASSERT_SAME(a_no_take_busy, clock, reset, hold_v_ff && cnt_ff != CORNER_D, !req_tready, "word taken while quad in flight")

endmodule

`default_nettype wire

// File: test/wide_line_quad_expander_unit_checker.sv
`timescale 1ns / 1ps

module wide_line_quad_expander_unit_checker
   import wlqe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [255:0]             req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [135:0]             rsp_tdata,
   input  logic                     rsp_tlast,
   input  logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending_count,
   output int                       square_count
);

   typedef struct packed {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic [31:0] color;
      corner_type  corner;
      logic        square;
      logic        last;
   } vertex_type;

   vertex_type       vertex_queue[$];
   logic [ZTHR_BITS-1:0] zero_len_thr;
   logic [DTHR_BITS-1:0] degen_thr;

   // round(c*w / (2*sqrt(xy2))), ties away from zero
   function automatic logic [63:0] offset_mag(logic [255:0] c, logic [255:0] w,
                                              logic [255:0] xy2);
      logic [255:0] cw, target, odd, lhs;
      logic [63:0] lo, hi, mid;
      cw = c * w;
      target = cw * cw;
      lo = '0;
      hi = w[63:0] + 1;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         odd = 256'(2 * mid - 1);
         lhs = odd * odd * xy2;
         if (lhs <= target) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic predict_quad(logic [255:0] d);
      logic [31:0] sx, sy, sz, ex, ey, ez, color, half, ox, oy;
      logic [31:0] vx[4], vy[4], vz[4];
      logic [30:0] w;
      longint dx, dy, dz;
      logic [255:0] ax, ay, az, xy2, len2;
      logic square, degen;
      vertex_type v;
      sx = d[31:0]; sy = d[63:32]; sz = d[95:64];
      ex = d[127:96]; ey = d[159:128]; ez = d[191:160];
      w = d[222:192]; color = d[254:223];
      half = (32'(w) + 1) >> 1;
      dx = longint'($signed(ex)) - longint'($signed(sx));
      dy = longint'($signed(ey)) - longint'($signed(sy));
      dz = longint'($signed(ez)) - longint'($signed(sz));
      ax = 256'(dx < 0 ? -dx : dx);
      ay = 256'(dy < 0 ? -dy : dy);
      az = 256'(dz < 0 ? -dz : dz);
      xy2 = ax * ax + ay * ay;
      len2 = xy2 + az * az;
      square = len2 < 256'(zero_len_thr);
      if (square) begin
         vx[0] = sx - half; vy[0] = sy - half;
         vx[1] = sx + half; vy[1] = sy - half;
         vx[2] = sx + half; vy[2] = sy + half;
         vx[3] = sx - half; vy[3] = sy + half;
         for (int k = 0; k < 4; k++) vz[k] = sz;
      end else begin
         degen = (xy2 == 0) || ((xy2 << 32) < 256'(degen_thr) * len2);
         if (degen) begin
            ox = half;
            oy = 0;
         end else begin
            ox = 32'(offset_mag(ay, 256'(w), xy2));
            oy = 32'(offset_mag(ax, 256'(w), xy2));
            if (dy > 0) ox = -ox;
            if (dx < 0) oy = -oy;
         end
         vx[0] = sx + ox; vy[0] = sy + oy; vz[0] = sz;
         vx[1] = sx - ox; vy[1] = sy - oy; vz[1] = sz;
         vx[2] = ex - ox; vy[2] = ey - oy; vz[2] = ez;
         vx[3] = ex + ox; vy[3] = ey + oy; vz[3] = ez;
      end
      if (square) square_count++;
      for (int k = 0; k < 4; k++) begin
         v.vx = vx[k]; v.vy = vy[k]; v.vz = vz[k];
         v.color = color;
         v.corner = corner_type'(k);
         v.square = square;
         v.last = corner_type'(k) == CORNER_D;
         vertex_queue.push_back(v);
      end
   endtask

   task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h actual %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      vertex_type v;
      if (reset) begin
         zero_len_thr <= ZTHR_RESET;
         degen_thr <= DTHR_RESET;
         fail_count = 0;
         square_count = 0;
         vertex_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr >> REG_INDEX_LSB))
               REG_ZTHR: zero_len_thr <= csr_pwdata[ZTHR_BITS-1:0];
               REG_DTHR: degen_thr <= csr_pwdata[DTHR_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_quad(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_queue.size() == 0) begin
               $error("vertex word with none expected");
               fail_count++;
            end else begin
               v = vertex_queue.pop_front();
               compare_field("vertex_x", v.vx, rsp_tdata[31:0]);
               compare_field("vertex_y", v.vy, rsp_tdata[63:32]);
               compare_field("vertex_z", v.vz, rsp_tdata[95:64]);
               compare_field("vertex_color", v.color, rsp_tdata[127:96]);
               compare_field("corner_index", 32'(v.corner), 32'(rsp_tdata[129:128]));
               compare_field("is_square", 32'(v.square), 32'(rsp_tuser));
               compare_field("is_last", 32'(v.last), 32'(rsp_tlast));
            end
         end
      end
      pending_count = vertex_queue.size();
   end

endmodule

// File: test/wide_line_quad_expander_unit_tb.sv
`timescale 1ns / 1ps

module wide_line_quad_expander_unit_tb
   import wlqe_pkg::*;
();

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [255:0]             req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [135:0]             rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int fail_count, pending_count, square_count;
   int idle_pct, stall_pct, sent_count, hold_left;
   bit hold_go, hold_done;

   wide_line_quad_expander_unit u_top (.*);

   wide_line_quad_expander_unit_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver side, with one long hold-off on request
   initial begin
      rsp_tready = 0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= $urandom_range(99) >= stall_pct;
         end
      end
   end

   task automatic send_segment(logic [31:0] sx, sy, sz, ex, ey, ez,
                               logic [30:0] w, logic [31:0] color);
      bit accepted;
      forever begin
         @(negedge clock);
         if ($urandom_range(99) >= idle_pct) break;
         req_tvalid <= 0;
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, color, w, ez, ey, ex, sz, sy, sx};
      accepted = 0;
      while (!accepted) begin
         @(posedge clock);
         accepted = req_tready;
      end
      sent_count++;
   endtask

   task automatic send_random();
      logic [31:0] sx, sy, sz, dx, dy, dz;
      logic [30:0] w;
      sx = $urandom; sy = $urandom; sz = $urandom;
      case ($urandom_range(4))
         0: begin
            dx = $urandom_range(80) - 40; dy = $urandom_range(80) - 40;
            dz = $urandom_range(80) - 40;
         end
         1: begin
            dx = $urandom; dy = $urandom; dz = $urandom;
         end
         2: begin
            dx = $urandom_range(1 << 21) - (1 << 20);
            dy = $urandom_range(1 << 21) - (1 << 20);
            dz = $urandom_range(1 << 21) - (1 << 20);
         end
         3: begin
            dx = $urandom_range(6) - 3; dy = $urandom_range(6) - 3;
            dz = $urandom;
         end
         default: begin
            dx = $urandom_range(1 << 17); dy = 0 - $urandom_range(1 << 17);
            dz = $urandom_range(255);
         end
      endcase
      w = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(1 << 18));
      send_segment(sx, sy, sz, sx + dx, sy + dy, sz + dz, w, $urandom);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_BITS'(idx) << REG_INDEX_LSB;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
   endtask

   task automatic drain_results();
      wait (pending_count == 0);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      req_tvalid = 0;
      req_tdata = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      sent_count = 0;
      hold_go = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed segments at reset thresholds
      send_segment(0, 0, 0, 0, 0, 0, 31'h10000, 32'hffffffff);
      send_segment(32'h100, 32'h200, 32'h300, 32'h110, 32'h205, 32'h300, 31'h7fffffff, 0);
      send_segment(32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 32'h12345678);
      send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000, 32'h80000000, 32'h80000000, 31'h1, 32'h89abcdef);
      send_segment(0, 0, 0, 32'h10000, 0, 0, 31'h0, 32'haaaaaaaa);
      send_segment(0, 0, 0, 32'hffff0000, 0, 0, 31'h20001, 32'h55555555);
      send_segment(0, 0, 0, 0, 32'h10000, 0, 31'h30000, 1);
      send_segment(0, 0, 0, 0, 32'hffff0000, 0, 31'h30003, 2);
      send_segment(0, 0, 0, 32'h30000, 32'h40000, 0, 31'h50000, 3);
      send_segment(0, 0, 0, 32'hfffd0000, 32'hfffc0000, 0, 31'h50001, 4);
      send_segment(0, 0, 0, 0, 0, 32'h100000, 31'h20003, 5);
      send_segment(5, 6, 7, 6, 6, 32'h7fff0000, 31'h40000, 6);
      send_segment(0, 0, 0, 32'h30, 32'h30, 0, 31'h3, 7);
      send_segment(0, 0, 0, 32'h41, 0, 0, 31'h7ffffffe, 8);
      send_segment(32'h7fff0000, 32'h7fff0000, 0, 32'h7fff0010, 32'h7fff0010, 0,
                   31'h7fffffff, 9);
      send_segment(32'h1, 32'h1, 32'h1, 32'h2, 32'h1, 32'h1, 31'h3fffffff, 10);
      send_segment(0, 0, 0, 32'h7, 32'h3, 0, 31'h7, 11);
      send_segment(0, 0, 0, 32'h1000000, 32'hff000000, 32'h1, 31'h123457, 12);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 86; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 86; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         idle_sender();
         drain_results();
         case (phase)
            0: begin
               write_reg(REG_ZTHR, 64'd4295);
               write_reg(REG_DTHR, 64'd43);
            end
            1: begin
               write_reg(REG_ZTHR, 64'd0);
               write_reg(REG_DTHR, 64'd0);
            end
            2: begin
               write_reg(REG_ZTHR, 64'h7fffffffffffffff);
               write_reg(REG_DTHR, 64'hffffffff);
            end
            default: begin
               write_reg(REG_ZTHR, 64'd1 << 20);
               write_reg(REG_DTHR, 64'd1 << 28);
            end
         endcase
         send_segment(0, 0, 0, 0, 0, 0, 31'h7fffffff, $urandom);
         send_segment(1, 2, 3, 1, 2, 32'h40000, 31'h1ffff, $urandom);
         for (int n = 0; n < 52; n++) begin
            if (phase == 0 && n == 10) hold_go = 1;
            if (phase == 3 && n == 26) begin
               idle_sender();
               wait (pending_count == 0);
            end
            send_random();
         end
         for (int n = 0; n < 3; n++) begin
            if (phase == 0) hold_go = 1;
         end
      end
      idle_sender();
      drain_results();

      $display("sent %0d segments, %0d drawn as squares", sent_count, square_count);
      $display("four threshold settings under no, sender, receiver and mixed idling");
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/wlqe_pkg.sv
rtl/wide_line_quad_expander_unit.sv
test/wide_line_quad_expander_unit_checker.sv
test/wide_line_quad_expander_unit_tb.sv
